>>> rtl/ctg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctg_pkg
// Shared widths, constants, data types and helpers for the circular
// trajectory generator.
// ----------------------------------------------------------------------------
package ctg_pkg;

  // default number of rotation cells in the chain
  localparam int CORDIC_STAGES_DEF = 16;

  // vector and angle widths (vector in Q2.30 with headroom)
  localparam int XY_W = 34;
  localparam int Z_W = 32;

  // product, shifted product and sum widths
  localparam int PROD_W = XY_W + 32;
  localparam int SHIFT_W = PROD_W - 30;
  localparam int SUM_W = SHIFT_W + 1;

  // phase constants, fractions of a full turn
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

  // start vector, pre-scaled by the inverse of the rotation gain
  localparam logic signed [XY_W-1:0] UNIT_INIT = XY_W'(652032875);

  // rounding constant, one half in Q30
  localparam logic signed [PROD_W-1:0] ROUND_HALF = {{(PROD_W - 30){1'b0}}, 1'b1, 29'b0};

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 3'd5;

  // arctangent of 2^-i in fractions of a full turn
  localparam logic [Z_W-1:0] ATAN_TURNS [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81,
    32'd41, 32'd20, 32'd10, 32'd5,
    32'd3, 32'd1, 32'd1, 32'd0
  };

  // sample bookkeeping carried alongside the vector
  typedef struct packed {
    logic [1:0]  quad;
    logic [15:0] idx;
    logic        last;
  } ctg_meta_t;

  // contents of one rotation cell
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    ctg_meta_t              meta;
  } ctg_vec_t;

  // clamp a wide signed sum to 32 bits
  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
    if ((&v[SUM_W-1:31]) || !(|v[SUM_W-1:31])) begin
      return v[31:0];
    end else if (v[SUM_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

endpackage

>>> rtl/circular_trajectory_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_trajectory_generator_unit
// Phase-accumulator oscillator with a chain of rotation cells, giving
// position and velocity of a point on a circle for each tick item.
// ----------------------------------------------------------------------------
// Takes one tick item per clock while in_stall is low and, in steady state
// with out_stall low, delivers one sample per clock. Each tick that yields a
// sample passes through CORDIC_STAGES rotation cells, then a quadrant stage,
// a product stage and the output register.
// The phase accumulator and sample counter update at the tick itself, so
// ticks after the final sample are taken at once and give nothing until a
// restart tick. Each stage has its own register and handshake: the chain
// keeps taking ticks while a finished sample waits at the output, until
// every stage holds an item. Configuration writes are always ready and
// belong to idle periods only.
// ----------------------------------------------------------------------------
module circular_trajectory_generator_unit import ctg_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // tick items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 restart,
  // samples
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   pos_x,
  output logic signed [31:0]   pos_y,
  output logic signed [31:0]   vel_x,
  output logic signed [31:0]   vel_y,
  output logic [15:0]          sample_index,
  output logic                 last
);

  // configuration registers
  logic [31:0]        phase_step;
  logic [30:0]        radius;
  logic [30:0]        speed;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [15:0]        sample_limit;

  // oscillator state
  logic [31:0] phase;
  logic [16:0] sample_count;
  logic [31:0] phase_eff;
  logic [16:0] count_eff;
  logic [31:0] phase_bias;
  logic        emit;
  logic        in_fire;

  // cell chain links
  logic     link_valid [0:CORDIC_STAGES];
  logic     link_ready [0:CORDIC_STAGES];
  ctg_vec_t link_data  [0:CORDIC_STAGES];

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= 32'd1;
      radius <= 31'd65536;
      speed <= 31'd65536;
      center_x <= '0;
      center_y <= '0;
      sample_limit <= 16'hffff;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_STEP:   phase_step <= cfg_data;
        REG_RADIUS:       radius <= cfg_data[30:0];
        REG_SPEED:        speed <= cfg_data[30:0];
        REG_CENTER_X:     center_x <= $signed(cfg_data);
        REG_CENTER_Y:     center_y <= $signed(cfg_data);
        REG_SAMPLE_LIMIT: sample_limit <= cfg_data[15:0];
        default:          ;
      endcase
    end
  end

  // tick decode: restart clears before the sample is taken
  always_comb begin
    phase_eff = restart ? '0 : phase;
    count_eff = restart ? '0 : sample_count;
    emit = count_eff <= {1'b0, sample_limit};
    phase_bias = phase_eff + EIGHTH_TURN;
  end

  assign in_stall = !link_ready[0];
  assign in_fire = in_valid && !in_stall;

  // phase accumulator and sample counter
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      sample_count <= '0;
    end else if (in_fire && emit) begin
      phase <= phase_eff + phase_step;
      sample_count <= count_eff + 17'd1;
    end
  end

  // entry of the chain: quadrant split and start vector
  always_comb begin
    link_valid[0] = in_valid && emit;
    link_data[0].x = UNIT_INIT;
    link_data[0].y = '0;
    link_data[0].z = $signed(phase_eff - {phase_bias[31:30], 30'b0});
    link_data[0].meta.quad = phase_bias[31:30];
    link_data[0].meta.idx = count_eff[15:0];
    link_data[0].meta.last = (count_eff == {1'b0, sample_limit});
  end

  // row of rotation cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ctg_cell #(
      .SHIFT (i),
      .ANGLE (ATAN_TURNS[i])
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (link_valid[i]),
      .up_ready (link_ready[i]),
      .up_data  (link_data[i]),
      .dn_valid (link_valid[i+1]),
      .dn_ready (link_ready[i+1]),
      .dn_data  (link_data[i+1])
    );
  end

  // scaling and output
  ctg_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (link_valid[CORDIC_STAGES]),
    .up_ready     (link_ready[CORDIC_STAGES]),
    .up_data      (link_data[CORDIC_STAGES]),
    .radius       (radius),
    .speed        (speed),
    .center_x     (center_x),
    .center_y     (center_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .sample_index (sample_index),
    .last         (last)
  );

endmodule

>>> rtl/ctg_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctg_cell
// One rotation cell: a single shift-add micro-rotation with its own
// register and handshake to the next cell.
// ----------------------------------------------------------------------------
module ctg_cell import ctg_pkg::*; #(
  parameter int             SHIFT = 0,
  parameter logic [Z_W-1:0] ANGLE = '0
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  ctg_vec_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output ctg_vec_t dn_data
);

  logic signed [XY_W-1:0] x_in;
  logic signed [XY_W-1:0] y_in;
  logic signed [XY_W-1:0] x_sh;
  logic signed [XY_W-1:0] y_sh;
  ctg_vec_t               vec_next;
  logic                   valid;
  ctg_vec_t               vec;

  // micro-rotation towards zero residual angle
  always_comb begin
    x_in = up_data.x;
    y_in = up_data.y;
    x_sh = x_in >>> SHIFT;
    y_sh = y_in >>> SHIFT;
    vec_next = up_data;
    if (!up_data.z[Z_W-1]) begin
      vec_next.x = x_in - y_sh;
      vec_next.y = y_in + x_sh;
      vec_next.z = up_data.z - ANGLE;
    end else begin
      vec_next.x = x_in + y_sh;
      vec_next.y = y_in - x_sh;
      vec_next.z = up_data.z + ANGLE;
    end
  end

  assign up_ready = !valid || dn_ready;

  // cell register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      vec <= vec_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data = vec;

endmodule

>>> rtl/ctg_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctg_scale
// Quadrant fold, radius and speed products, rounding, centre offset and
// saturation, ending in the output register.
// ----------------------------------------------------------------------------
module ctg_scale import ctg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  ctg_vec_t           up_data,
  input  logic [30:0]        radius,
  input  logic [30:0]        speed,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic [15:0]        sample_index,
  output logic               last
);

  // quadrant stage
  logic                   q_valid;
  logic                   q_ready;
  logic signed [XY_W-1:0] q_cos;
  logic signed [XY_W-1:0] q_sin;
  logic signed [XY_W-1:0] q_nsin;
  ctg_meta_t              q_meta;
  logic signed [XY_W-1:0] cos_next;
  logic signed [XY_W-1:0] sin_next;

  // product stage
  logic                     m_valid;
  logic                     m_ready;
  logic signed [PROD_W-1:0] m_px;
  logic signed [PROD_W-1:0] m_py;
  logic signed [PROD_W-1:0] m_vx;
  logic signed [PROD_W-1:0] m_vy;
  ctg_meta_t                m_meta;
  logic signed [31:0]       rad_s;
  logic signed [31:0]       spd_s;

  // output stage
  logic                      o_ready;
  logic signed [PROD_W-1:0]  rnd_px;
  logic signed [PROD_W-1:0]  rnd_py;
  logic signed [PROD_W-1:0]  rnd_vx;
  logic signed [PROD_W-1:0]  rnd_vy;
  logic signed [SUM_W-1:0]   sum_px;
  logic signed [SUM_W-1:0]   sum_py;
  logic signed [SUM_W-1:0]   sum_vx;
  logic signed [SUM_W-1:0]   sum_vy;

  // fold the quarter turn back in by swaps and negations
  always_comb begin
    unique case (up_data.meta.quad)
      2'd0: begin
        cos_next = up_data.x;
        sin_next = up_data.y;
      end
      2'd1: begin
        cos_next = -up_data.y;
        sin_next = up_data.x;
      end
      2'd2: begin
        cos_next = -up_data.x;
        sin_next = -up_data.y;
      end
      default: begin
        cos_next = up_data.y;
        sin_next = -up_data.x;
      end
    endcase
  end

  assign up_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (up_ready) begin
      q_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      q_cos <= cos_next;
      q_sin <= sin_next;
      q_nsin <= -sin_next;
      q_meta <= up_data.meta;
    end
  end

  // radius and speed products
  assign rad_s = $signed({1'b0, radius});
  assign spd_s = $signed({1'b0, speed});
  assign q_ready = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (q_ready) begin
      m_valid <= q_valid;
    end
    if (q_ready && q_valid) begin
      m_px <= PROD_W'(rad_s * q_cos);
      m_py <= PROD_W'(rad_s * q_sin);
      m_vx <= PROD_W'(spd_s * q_nsin);
      m_vy <= PROD_W'(spd_s * q_cos);
      m_meta <= q_meta;
    end
  end

  // round half up, drop 30 fraction bits, add centre to the position
  always_comb begin
    rnd_px = m_px + ROUND_HALF;
    rnd_py = m_py + ROUND_HALF;
    rnd_vx = m_vx + ROUND_HALF;
    rnd_vy = m_vy + ROUND_HALF;
    sum_px = SUM_W'($signed(rnd_px[PROD_W-1:30])) + SUM_W'(center_x);
    sum_py = SUM_W'($signed(rnd_py[PROD_W-1:30])) + SUM_W'(center_y);
    sum_vx = SUM_W'($signed(rnd_vx[PROD_W-1:30]));
    sum_vy = SUM_W'($signed(rnd_vy[PROD_W-1:30]));
  end

  assign o_ready = !out_stall;
  assign m_ready = !out_valid || o_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (m_ready) begin
      out_valid <= m_valid;
    end
    if (m_ready && m_valid) begin
      pos_x <= sat32(sum_px);
      pos_y <= sat32(sum_py);
      vel_x <= sat32(sum_vx);
      vel_y <= sat32(sum_vy);
      sample_index <= m_meta.idx;
      last <= m_meta.last;
    end
  end

endmodule
